@@ rtl/core/arpp_pkg.sv @@
`timescale 1ns / 1ps

package arpp_pkg;

    localparam int RING_FRAMES  = 16384;
    localparam int CHANNELS     = 2;
    localparam int RING_SAMPLES = RING_FRAMES * CHANNELS;

    localparam int START_W = 14;
    localparam int SEG_W   = 15;
    localparam int POS_W   = 15;
    localparam int LIM_W   = 15;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_REBASE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] KIND_RING    = 2'd0;
    localparam logic [1:0] KIND_SILENCE = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;

    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_CATCHUP = 2'd1;

    localparam logic [LIM_W-1:0] CATCHUP_RESET = 15'd5512;

    typedef struct packed {
        logic             enabled;
        logic [LIM_W-1:0] catchup_limit;
    } t_cfg;

    // at most one job per input, expanded into results by the back end
    typedef struct packed {
        logic               has_r1;
        logic               has_r2;
        logic               has_sil;
        logic               is_rpt;
        logic [START_W-1:0] start;
        logic [SEG_W-1:0]   c1;
        logic [SEG_W-1:0]   c2;
        logic [31:0]        sil;
        logic [POS_W-1:0]   pos;
        logic [31:0]        run;
    } t_job;

endpackage

@@ rtl/core/audio_ring_playout_pacer.sv @@
`timescale 1ns / 1ps

// Playout pacer for a 16384-frame, two-channel mixer ring. The front end takes
// a submit through a small sequencer of four steps (painted clamp, backlog
// against the sent count, catch-up window and ring split, hand-off) and
// accepts no new command before the hand-off; a position query goes
// straight to the hand-off; a rebase is applied in the cycle it is accepted.
// A two-job queue sits between the front end and the result stage, which emits
// one result per cycle while the consumer is ready (up to three per submit: two
// ring segments and one silence segment) through a registered output, so a
// stalled consumer does not hold the front end until the queue fills. The first
// result of an item passes the queue entry, the job register of the result
// stage and the output register. No clearing pass after reset.

module audio_ring_playout_pacer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [31:0]                     i_elapsed_frames,
    input  logic [31:0]                     i_painted_frame,
    input  logic [30:0]                     i_rebase_frames,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_kind,
    output logic [arpp_pkg::START_W-1:0]    o_start_frame,
    output logic [31:0]                     o_frame_count,
    output logic [arpp_pkg::POS_W-1:0]      o_ring_sample_pos,
    output logic [31:0]                     o_running_count,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [arpp_pkg::LIM_W-1:0]      i_cfg_data
);

    arpp_pkg::t_cfg r_cfg;
    arpp_pkg::t_job w_push_job;
    arpp_pkg::t_job w_pop_job;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled       <= 1'b0;
            r_cfg.catchup_limit <= arpp_pkg::CATCHUP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                arpp_pkg::CFG_ENABLED: begin
                    r_cfg.enabled <= i_cfg_data[0];
                end
                arpp_pkg::CFG_CATCHUP: begin
                    r_cfg.catchup_limit <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    arpp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_elapsed_frames (i_elapsed_frames),
        .i_painted_frame  (i_painted_frame),
        .i_rebase_frames  (i_rebase_frames),
        .i_cfg            (r_cfg),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_job            (w_push_job)
    );

    arpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    arpp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (w_empty),
        .i_job             (w_pop_job),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_start_frame     (o_start_frame),
        .o_frame_count     (o_frame_count),
        .o_ring_sample_pos (o_ring_sample_pos),
        .o_running_count   (o_running_count),
        .o_last            (o_last)
    );

    // ring segments are never empty and never run past the ring end
    a_ring_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == arpp_pkg::KIND_RING) |->
            (o_frame_count != '0) &&
            ((o_frame_count + 32'(o_start_frame)) <= 32'(arpp_pkg::RING_FRAMES)))
        else $error("ring segment length out of range");

    // a position report is always the only result of its query
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == arpp_pkg::KIND_REPORT) |-> o_last &&
            (o_frame_count == '0))
        else $error("report not single or carries a count");

    // the queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job queue overflow");

    // only ring segments carry a start frame
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != arpp_pkg::KIND_RING) |-> (o_start_frame == '0))
        else $error("start frame set outside a ring segment");

endmodule

@@ rtl/core/arpp_front.sv @@
`timescale 1ns / 1ps

module arpp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_cmd,
    input  logic [31:0]         i_elapsed_frames,
    input  logic [31:0]         i_painted_frame,
    input  logic [30:0]         i_rebase_frames,
    input  arpp_pkg::t_cfg      i_cfg,
    input  logic                i_q_full,
    output logic                o_push,
    output arpp_pkg::t_job      o_job
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CLAMP = 3'd1;
    localparam logic [2:0] PH_GAP   = 3'd2;
    localparam logic [2:0] PH_SPLIT = 3'd3;
    localparam logic [2:0] PH_PUSH  = 3'd4;

    logic [2:0]                     r_ph, n_ph;
    logic [31:0]                    r_sent, n_sent;
    logic [31:0]                    r_base, n_base;
    logic [1:0]                     r_cmd, n_cmd;
    logic [31:0]                    r_due, n_due;
    logic [31:0]                    r_painted, n_painted;
    logic [31:0]                    r_upto, n_upto;
    logic [31:0]                    r_gap, n_gap;
    logic [arpp_pkg::SEG_W-1:0]     r_g, n_g;
    logic [arpp_pkg::START_W-1:0]   r_first, n_first;
    logic [31:0]                    r_sil, n_sil;
    logic                           r_silv, n_silv;

    logic                           w_accept;
    logic                           w_submit;
    logic                           w_push_ok;
    logic                           w_nonempty;
    logic [31:0]                    w_d1;
    logic [31:0]                    w_diff;
    logic [31:0]                    w_dsil;
    logic [arpp_pkg::LIM_W-1:0]     w_lim;
    logic [arpp_pkg::SEG_W-1:0]     w_gmin;
    logic [arpp_pkg::SEG_W-1:0]     w_room;
    logic [arpp_pkg::SEG_W-1:0]     w_c1;
    logic [arpp_pkg::SEG_W-1:0]     w_c2;
    logic [31:0]                    w_scaled;
    logic [31:0]                    w_sent_base;

    assign w_accept = i_valid && o_ready;
    assign w_submit = (r_cmd == arpp_pkg::CMD_SUBMIT);

    // split the clamped backlog at the ring wrap
    assign w_room = arpp_pkg::SEG_W'(arpp_pkg::RING_FRAMES) - {1'b0, r_first};
    assign w_c1   = (r_g > w_room) ? w_room : r_g;
    assign w_c2   = r_g - w_c1;

    assign w_scaled = r_due * 32'(arpp_pkg::CHANNELS);

    always_comb begin
        o_job.has_r1  = w_submit && (r_g != '0);
        o_job.has_r2  = w_submit && (w_c2 != '0);
        o_job.has_sil = w_submit && r_silv;
        o_job.is_rpt  = (r_cmd == arpp_pkg::CMD_QUERY);
        o_job.start   = r_first;
        o_job.c1      = w_c1;
        o_job.c2      = w_c2;
        o_job.sil     = r_sil;
        o_job.pos     = i_cfg.enabled ?
                        arpp_pkg::POS_W'(w_scaled % 32'(arpp_pkg::RING_SAMPLES)) : '0;
        o_job.run     = i_cfg.enabled ? r_due : '0;
    end

    assign w_nonempty = o_job.has_r1 || o_job.has_r2 || o_job.has_sil || o_job.is_rpt;
    assign w_push_ok  = (r_ph == PH_PUSH) && (!w_nonempty || !i_q_full);
    assign o_push     = w_push_ok && w_nonempty;
    assign o_ready    = (r_ph == PH_IDLE) || w_push_ok;

    assign w_d1   = r_due - r_painted;
    assign w_diff = r_upto - r_sent;
    assign w_dsil = r_due - r_upto;
    assign w_lim  = (i_cfg.catchup_limit > arpp_pkg::LIM_W'(arpp_pkg::RING_FRAMES)) ?
                    arpp_pkg::LIM_W'(arpp_pkg::RING_FRAMES) : i_cfg.catchup_limit;
    assign w_gmin = (r_gap > 32'(w_lim)) ? w_lim : r_gap[arpp_pkg::SEG_W-1:0];

    // sent count at the end of a submit, before any rebase in the same cycle
    assign w_sent_base = (w_push_ok && w_submit) ? (r_silv ? r_due : r_upto) : r_sent;

    always_comb begin
        n_ph      = r_ph;
        n_base    = r_base;
        n_sent    = w_sent_base;
        n_cmd     = r_cmd;
        n_due     = r_due;
        n_painted = r_painted;
        n_upto    = r_upto;
        n_gap     = r_gap;
        n_g       = r_g;
        n_first   = r_first;
        n_sil     = r_sil;
        n_silv    = r_silv;

        case (r_ph)
            PH_IDLE: begin
            end
            PH_CLAMP: begin
                // mixer behind the due point: send only what is painted
                n_upto = ((w_d1 != '0) && !w_d1[31]) ? r_painted : r_due;
                n_ph   = PH_GAP;
            end
            PH_GAP: begin
                if (w_diff[31]) begin
                    n_upto = r_sent;
                    n_gap  = '0;
                end else begin
                    n_gap  = w_diff;
                end
                n_ph = PH_SPLIT;
            end
            PH_SPLIT: begin
                n_g     = w_gmin;
                n_first = arpp_pkg::START_W'(r_upto - 32'(w_gmin));
                n_sil   = w_dsil;
                n_silv  = (w_dsil != '0) && !w_dsil[31];
                n_ph    = PH_PUSH;
            end
            PH_PUSH: begin
                if (w_push_ok) begin
                    n_ph = PH_IDLE;
                end
            end
            default: begin
                n_ph = PH_IDLE;
            end
        endcase

        if (w_accept) begin
            n_cmd     = i_cmd;
            n_due     = i_elapsed_frames - r_base;
            n_painted = i_painted_frame;
            case (i_cmd)
                arpp_pkg::CMD_SUBMIT: begin
                    if (i_cfg.enabled) begin
                        n_ph = PH_CLAMP;
                    end
                end
                arpp_pkg::CMD_QUERY: begin
                    n_ph = PH_PUSH;
                end
                arpp_pkg::CMD_REBASE: begin
                    n_base = r_base + {1'b0, i_rebase_frames};
                    n_sent = w_sent_base - {1'b0, i_rebase_frames};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_sent <= '0;
            r_base <= '0;
        end else begin
            r_ph   <= n_ph;
            r_sent <= n_sent;
            r_base <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_due     <= n_due;
        r_painted <= n_painted;
        r_upto    <= n_upto;
        r_gap     <= n_gap;
        r_g       <= n_g;
        r_first   <= n_first;
        r_sil     <= n_sil;
        r_silv    <= n_silv;
    end

endmodule

@@ rtl/core/arpp_queue.sv @@
`timescale 1ns / 1ps

module arpp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  arpp_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output arpp_pkg::t_job  o_job,
    output logic            o_empty
);

    arpp_pkg::t_job r_mem [2];
    logic           r_wr, n_wr;
    logic           r_rd, n_rd;
    logic [1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr ^ i_push;
        n_rd  = r_rd ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

@@ rtl/core/arpp_back.sv @@
`timescale 1ns / 1ps

module arpp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  arpp_pkg::t_job                  i_job,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_kind,
    output logic [arpp_pkg::START_W-1:0]    o_start_frame,
    output logic [31:0]                     o_frame_count,
    output logic [arpp_pkg::POS_W-1:0]      o_ring_sample_pos,
    output logic [31:0]                     o_running_count,
    output logic                            o_last
);

    localparam logic [3:0] SEL_RING1   = 4'b0001;
    localparam logic [3:0] SEL_RING2   = 4'b0010;
    localparam logic [3:0] SEL_SILENCE = 4'b0100;
    localparam logic [3:0] SEL_REPORT  = 4'b1000;

    arpp_pkg::t_job                 r_job;
    logic [3:0]                     r_rem, n_rem;
    logic                           r_valid;
    logic [1:0]                     r_kind, n_kind;
    logic [arpp_pkg::START_W-1:0]   r_start, n_start;
    logic [31:0]                    r_count, n_count;
    logic [arpp_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [31:0]                    r_run, n_run;
    logic                           r_last;

    logic                           w_load;
    logic                           w_emit;
    logic [3:0]                     w_sel;
    logic [3:0]                     w_rem_after;

    assign w_load      = !r_valid || i_ready;
    assign w_emit      = w_load && (r_rem != '0);
    assign w_sel       = r_rem & (~r_rem + 4'd1);
    assign w_rem_after = r_rem & ~w_sel;

    // take the next job when none is in hand or as the current one hands out its final result
    assign o_pop = !i_empty && ((r_rem == '0) || (w_emit && (w_rem_after == '0)));

    always_comb begin
        n_rem = r_rem;
        if (o_pop) begin
            n_rem = {i_job.is_rpt, i_job.has_sil, i_job.has_r2, i_job.has_r1};
        end else if (w_emit) begin
            n_rem = w_rem_after;
        end
    end

    always_comb begin
        n_kind  = arpp_pkg::KIND_RING;
        n_start = '0;
        n_count = '0;
        n_pos   = '0;
        n_run   = '0;
        case (w_sel)
            SEL_RING1: begin
                n_start = r_job.start;
                n_count = 32'(r_job.c1);
            end
            SEL_RING2: begin
                n_count = 32'(r_job.c2);
            end
            SEL_SILENCE: begin
                n_kind  = arpp_pkg::KIND_SILENCE;
                n_count = r_job.sil;
            end
            SEL_REPORT: begin
                n_kind = arpp_pkg::KIND_REPORT;
                n_pos  = r_job.pos;
                n_run  = r_job.run;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rem <= n_rem;
            if (w_load) begin
                r_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_kind  <= n_kind;
            r_start <= n_start;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_run   <= n_run;
            r_last  <= (w_rem_after == '0);
        end
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_start_frame     = r_start;
    assign o_frame_count     = r_count;
    assign o_ring_sample_pos = r_pos;
    assign o_running_count   = r_run;
    assign o_last            = r_last;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 335;

    // command code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [31:0] RING_LEN = 32'(arpp_pkg::RING_FRAMES);

    typedef struct packed {
        logic [1:0]                   kind;
        logic [arpp_pkg::START_W-1:0] start;
        logic [31:0]                  count;
        logic [arpp_pkg::POS_W-1:0]   pos;
        logic [31:0]                  run;
        logic                         last;
    } t_playout;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [1:0]                   i_cmd = arpp_pkg::CMD_SUBMIT;
    logic [31:0]                  i_elapsed_frames = '0;
    logic [31:0]                  i_painted_frame = '0;
    logic [30:0]                  i_rebase_frames = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [1:0]                   o_kind;
    logic [arpp_pkg::START_W-1:0] o_start_frame;
    logic [31:0]                  o_frame_count;
    logic [arpp_pkg::POS_W-1:0]   o_ring_sample_pos;
    logic [31:0]                  o_running_count;
    logic                         o_last;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [1:0]                   i_cfg_index = arpp_pkg::CFG_ENABLED;
    logic [arpp_pkg::LIM_W-1:0]   i_cfg_data = '0;

    // predicted block state and registers
    logic [31:0]                  sent_cnt = '0;
    logic [31:0]                  clk_base = '0;
    logic                         cfg_en = 1'b0;
    logic [arpp_pkg::LIM_W-1:0]   cfg_catchup = arpp_pkg::CATCHUP_RESET;

    t_playout           playout_q[$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 rx_wait = 0;
    bit                 tx_burst = 1'b0;
    bit                 rx_burst = 1'b0;

    audio_ring_playout_pacer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_elapsed_frames  (i_elapsed_frames),
        .i_painted_frame   (i_painted_frame),
        .i_rebase_frames   (i_rebase_frames),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_start_frame     (o_start_frame),
        .o_frame_count     (o_frame_count),
        .o_ring_sample_pos (o_ring_sample_pos),
        .o_running_count   (o_running_count),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // works out the segments or report that one accepted command produces
    function automatic void plan_playout(input logic [1:0] cmd, input logic [31:0] el,
                                         input logic [31:0] pa, input logic [30:0] rb);
        t_playout    segs[3];
        t_playout    r;
        int          n;
        logic [31:0] due;
        logic [31:0] upto;
        logic [31:0] lim;
        logic [31:0] d;
        logic [31:0] first;
        logic [31:0] count;
        logic [31:0] prod;
        logic [31:0] pos_full;

        n = 0;
        if (cmd == arpp_pkg::CMD_REBASE) begin
            clk_base = clk_base + {1'b0, rb};
            sent_cnt = sent_cnt - {1'b0, rb};
            return;
        end
        if (cmd == arpp_pkg::CMD_QUERY) begin
            r = '0;
            r.kind = arpp_pkg::KIND_REPORT;
            r.last = 1'b1;
            if (cfg_en) begin
                r.run = el - clk_base;
                prod = r.run * 32'(arpp_pkg::CHANNELS);
                pos_full = prod % 32'(arpp_pkg::RING_SAMPLES);
                r.pos = pos_full[arpp_pkg::POS_W-1:0];
            end
            playout_q.push_back(r);
            return;
        end
        if (cmd != arpp_pkg::CMD_SUBMIT || !cfg_en)
            return;

        due = el - clk_base;
        upto = due;
        lim = {17'd0, cfg_catchup};
        if (lim > RING_LEN)
            lim = RING_LEN;

        d = upto - pa;
        if (d != 0 && !d[31])
            upto = pa;
        d = upto - sent_cnt;
        if (d[31])
            upto = sent_cnt;
        d = upto - sent_cnt;
        if (d > lim)
            sent_cnt = upto - lim;

        // at most two ring pieces, split where the ring wraps
        while (sent_cnt != upto && n < 2) begin
            first = sent_cnt % RING_LEN;
            count = upto - sent_cnt;
            if (count > RING_LEN - first)
                count = RING_LEN - first;
            r = '0;
            r.kind = arpp_pkg::KIND_RING;
            r.start = first[arpp_pkg::START_W-1:0];
            r.count = count;
            segs[n] = r;
            n++;
            sent_cnt = sent_cnt + count;
        end

        d = due - sent_cnt;
        if (d != 0 && !d[31]) begin
            r = '0;
            r.kind = arpp_pkg::KIND_SILENCE;
            r.count = d;
            segs[n] = r;
            n++;
            sent_cnt = due;
        end

        for (int k = 0; k < n; k++) begin
            r = segs[k];
            r.last = (k == n - 1);
            playout_q.push_back(r);
        end
    endfunction

    // result side: random stalls, every transaction checked against the oldest prediction
    always @(posedge i_clk) begin
        t_playout got;
        t_playout want;

        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_kind, o_start_frame, o_frame_count, o_ring_sample_pos,
                        o_running_count, o_last};
                if (playout_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("cycle %0d: result with nothing pending, kind %0d count %0h",
                                 cycles, got.kind, got.count);
                end else begin
                    want = playout_q.pop_front();
                    if (got.kind !== want.kind || got.start !== want.start ||
                        got.count !== want.count || got.pos !== want.pos ||
                        got.run !== want.run || got.last !== want.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $write("cycle %0d mismatch exp: kind %0d start %0d count %0h ",
                                   cycles, want.kind, want.start, want.count);
                            $display("pos %0d run %0h last %0d", want.pos, want.run,
                                     want.last);
                            $write("    got: kind %0d start %0d count %0h ",
                                   got.kind, got.start, got.count);
                            $display("pos %0d run %0h last %0d", got.pos, got.run,
                                     got.last);
                        end
                    end
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
            end
            if (rx_wait > 0) begin
                i_ready <= 1'b0;
                rx_wait--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic issue_cmd(input logic [1:0] cmd, input logic [31:0] el,
                             input logic [31:0] pa, input logic [30:0] rb);
        int gap;

        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_elapsed_frames <= el;
        i_painted_frame <= pa;
        i_rebase_frames <= rb;
        do @(posedge i_clk); while (!o_ready);
        plan_playout(cmd, el, pa, rb);
    endtask

    // stop sending and let every pending result and any silent work finish
    task automatic drain_playout();
        i_valid <= 1'b0;
        while (playout_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [arpp_pkg::LIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == arpp_pkg::CFG_ENABLED)
            cfg_en = val[0];
        else if (idx == arpp_pkg::CFG_CATCHUP)
            cfg_catchup = val;
        @(posedge i_clk);
    endtask

    task automatic test_disabled();
        issue_cmd(arpp_pkg::CMD_SUBMIT, 32'd1000, 32'd1000, '0);
        issue_cmd(arpp_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        issue_cmd(arpp_pkg::CMD_REBASE, '0, '0, 31'h7FFF_FFFF);
        issue_cmd(CMD_UNUSED, '1, '1, '1);
        drain_playout();
        write_reg(arpp_pkg::CFG_ENABLED, 15'd1);
    endtask

    task automatic test_submit_cases();
        logic [31:0] b;

        b = clk_base;
        issue_cmd(arpp_pkg::CMD_QUERY, b, '0, '0);
        // sent count far off after the big rebase: window trim and wrap split
        issue_cmd(arpp_pkg::CMD_SUBMIT, b, 32'd0, '0);
        issue_cmd(arpp_pkg::CMD_SUBMIT, b + 100, 32'd100, '0);
        issue_cmd(arpp_pkg::CMD_SUBMIT, b + 300, 32'd200, '0);
        issue_cmd(arpp_pkg::CMD_SUBMIT, b + 400, 32'd50, '0);
        issue_cmd(arpp_pkg::CMD_SUBMIT, b + 400, 32'd400, '0);
        issue_cmd(arpp_pkg::CMD_SUBMIT, b + 10, 32'd10, '0);
        issue_cmd(arpp_pkg::CMD_SUBMIT, b + 16500, 32'd16450, '0);
        issue_cmd(arpp_pkg::CMD_QUERY, 32'hFFFF_FFFF, '0, '0);
        issue_cmd(CMD_UNUSED, '1, '1, '1);
        issue_cmd(arpp_pkg::CMD_REBASE, '0, '0, 31'd1000);
        issue_cmd(arpp_pkg::CMD_SUBMIT, b + 17000, 32'h7FFF_FFFF, '0);
        issue_cmd(arpp_pkg::CMD_SUBMIT, b + 17100, 32'h8000_0000, '0);
        drain_playout();
    endtask

    task automatic test_catchup_window();
        logic [arpp_pkg::LIM_W-1:0] lims[4];
        logic [31:0]                el;

        lims = '{15'd0, 15'd1, 15'd16384, 15'd32767};
        foreach (lims[k]) begin
            write_reg(arpp_pkg::CFG_CATCHUP, lims[k]);
            el = clk_base + sent_cnt + 20000;
            issue_cmd(arpp_pkg::CMD_SUBMIT, el, el - clk_base - 10, '0);
            issue_cmd(arpp_pkg::CMD_QUERY, el, '0, '0);
            drain_playout();
        end
        write_reg(arpp_pkg::CFG_CATCHUP, arpp_pkg::CATCHUP_RESET);
    endtask

    task automatic test_random_playout();
        int          taken;
        int          iter;
        int          roll;
        logic [1:0]  cmd;
        logic [31:0] el;
        logic [31:0] pa;
        logic [30:0] rb;
        logic [31:0] play_clock;

        taken = 0;
        iter = 0;
        play_clock = clk_base + sent_cnt;
        while (taken < RANDOM_ITEMS) begin
            if (iter % 45 == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            if (iter == 130) begin
                drain_playout();
                write_reg(arpp_pkg::CFG_CATCHUP, 15'($urandom_range(0, 16384)));
            end else if (iter == 200) begin
                drain_playout();
            end else if (iter == 260) begin
                drain_playout();
                write_reg(arpp_pkg::CFG_ENABLED, 15'd0);
            end else if (iter == 280) begin
                drain_playout();
                write_reg(arpp_pkg::CFG_ENABLED, 15'd1);
                write_reg(arpp_pkg::CFG_CATCHUP, 15'($urandom_range(16384, 32767)));
            end else if (iter == 320) begin
                drain_playout();
                write_reg(arpp_pkg::CFG_CATCHUP, 15'($urandom_range(1, 8000)));
            end

            roll = $urandom_range(0, 99);
            rb = 31'($urandom);
            el = $urandom;
            pa = $urandom;
            if (roll < 10) begin
                cmd = 2'($urandom);
            end else if (roll < 18) begin
                cmd = arpp_pkg::CMD_REBASE;
                rb = 31'($urandom_range(0, 30000));
            end else if (roll < 30) begin
                cmd = arpp_pkg::CMD_QUERY;
                el = play_clock + $urandom_range(0, 50);
            end else begin
                cmd = arpp_pkg::CMD_SUBMIT;
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    play_clock = play_clock + $urandom_range(0, 40000);
                else if (roll < 10)
                    play_clock = play_clock - $urandom_range(0, 200);
                else
                    play_clock = play_clock + $urandom_range(0, 700);
                el = play_clock;
                // painted point near the due point, a little ahead or behind
                pa = el - clk_base + $urandom_range(0, 600) - 32'd300;
            end

            issue_cmd(cmd, el, pa, rb);
            if (!(cmd == CMD_UNUSED || (cmd == arpp_pkg::CMD_SUBMIT && !cfg_en)))
                taken++;
            iter++;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled();
        test_submit_cases();
        test_catchup_window();
        test_random_playout();
        drain_playout();

        if (errors == 0 && playout_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/arpp_pkg.sv
rtl/core/arpp_front.sv
rtl/core/arpp_queue.sv
rtl/core/arpp_back.sv
rtl/core/audio_ring_playout_pacer.sv
bench/tb_top.sv
